>>> src/assert_macros.svh
// assertion macros shared by the rtl files
// each macro expects clk and rst in scope
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define AFC_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication
`define AFC_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

>>> src/afc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package afc_pkg;

  // samples per window
  localparam int WINDOW_SAMPLES = 2;
  localparam logic [19:0] WIN_DIV = 20'(WINDOW_SAMPLES);
  localparam logic [4:0] WIN_LEN = 5'(WINDOW_SAMPLES);

  // saturation limits
  localparam logic [19:0] SUM_MAX = 20'hFFFFF;
  localparam logic [4:0] FALL_RUN_MAX = 5'd31;

  // motion level codes
  localparam logic [1:0] LVL_STILL = 2'd0;
  localparam logic [1:0] LVL_MICRO = 2'd1;
  localparam logic [1:0] LVL_MOVING = 2'd2;

  // register indexes
  localparam logic [1:0] REG_QUIET_TH = 2'd0;
  localparam logic [1:0] REG_ACTIVE_TH = 2'd1;
  localparam logic [1:0] REG_FALL_TH = 2'd2;
  localparam logic [1:0] REG_FALL_WIN = 2'd3;

  // register reset values
  localparam logic [17:0] QUIET_TH_RST = 18'd1000;
  localparam logic [17:0] ACTIVE_TH_RST = 18'd8000;
  localparam logic [17:0] FALL_TH_RST = 18'd30000;
  localparam logic [3:0] FALL_WIN_RST = 4'd3;

  typedef struct packed {
    logic [17:0] quiet_threshold;
    logic [17:0] active_threshold;
    logic [17:0] fall_threshold;
    logic [3:0]  fall_windows;
  } cfg_t;

  typedef struct packed {
    logic        window_done;
    logic [17:0] window_score;
    logic [1:0]  motion_level;
    logic        fall_seen;
  } result_t;

endpackage

`default_nettype wire

>>> src/accel_activity_fall_classifier.sv
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

// Accelerometer activity and fall classifier. One three-axis sample is taken
// per clock while in_stall is low; its result (window flag, last window score,
// motion level and the sticky fall flag) is registered on the following cycle
// in a two-entry output buffer, which lets the block take a new sample while
// one result waits; in_stall rises only when both entries are full. Thresholds
// and the fall window count are written through the cfg port; the user must do
// so only while the block is idle, as the block itself does not enforce this.
module accel_activity_fall_classifier import afc_pkg::*; (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic signed [15:0] accel_x,
  input  wire logic signed [15:0] accel_y,
  input  wire logic signed [15:0] accel_z,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic                    window_done,
  output logic [17:0]             window_score,
  output logic [1:0]              motion_level,
  output logic                    fall_seen,
  input  wire logic               cfg_we,
  input  wire logic [1:0]         cfg_index,
  input  wire logic [17:0]        cfg_data
);

  cfg_t    cfg;
  result_t res;
  result_t out_data;
  result_t skid_data;
  logic    skid_valid;
  logic    fire;
  logic    out_take;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.quiet_threshold <= QUIET_TH_RST;
      cfg.active_threshold <= ACTIVE_TH_RST;
      cfg.fall_threshold <= FALL_TH_RST;
      cfg.fall_windows <= FALL_WIN_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_QUIET_TH:  cfg.quiet_threshold <= cfg_data;
        REG_ACTIVE_TH: cfg.active_threshold <= cfg_data;
        REG_FALL_TH:   cfg.fall_threshold <= cfg_data;
        REG_FALL_WIN:  cfg.fall_windows <= cfg_data[3:0];
        default: begin
        end
      endcase
    end
  end

  // handshake
  assign in_stall = skid_valid;
  assign fire = in_valid && !skid_valid;
  assign out_take = out_valid && !out_stall;

  afc_core u_core (
    .clk     (clk),
    .rst     (rst),
    .fire    (fire),
    .accel_x (accel_x),
    .accel_y (accel_y),
    .accel_z (accel_z),
    .cfg     (cfg),
    .res     (res)
  );

  // output register with skid entry
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (out_take) begin
        skid_valid <= 1'b0;
      end
    end else if (fire) begin
      if (out_valid && !out_take) begin
        skid_valid <= 1'b1;
      end else begin
        out_valid <= 1'b1;
      end
    end else if (out_take) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (out_take) begin
        out_data <= skid_data;
      end
    end else if (fire) begin
      if (out_valid && !out_take) begin
        skid_data <= res;
      end else begin
        out_data <= res;
      end
    end
  end

  assign window_done = out_data.window_done;
  assign window_score = out_data.window_score;
  assign motion_level = out_data.motion_level;
  assign fall_seen = out_data.fall_seen;

  `AFC_ASSERT_NOW(a_skid_needs_out, skid_valid, out_valid)
  `AFC_ASSERT_NEXT(a_skid_fill, fire && out_valid && out_stall, skid_valid)
  `AFC_ASSERT_NEXT(a_out_fill, fire, out_valid)

endmodule

`default_nettype wire

>>> src/afc_core.sv
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module afc_core import afc_pkg::*; (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               fire,
  input  wire logic signed [15:0] accel_x,
  input  wire logic signed [15:0] accel_y,
  input  wire logic signed [15:0] accel_z,
  input  wire cfg_t               cfg,
  output result_t                 res
);

  // state
  logic signed [15:0] prev_x, prev_y, prev_z;
  logic [19:0] window_sum, window_sum_next;
  logic [3:0]  samples_in_window, samples_in_window_next;
  logic [1:0]  level_state, level_state_next;
  logic [1:0]  quiet_run, quiet_run_next;
  logic [4:0]  fall_run, fall_run_next;
  logic        fall_flag, fall_flag_next;
  logic [17:0] last_score, last_score_next;

  // working values
  logic signed [16:0] dx, dy, dz;
  logic [16:0] ax, ay, az;
  logic [17:0] sabs;
  logic [20:0] sum_wide;
  logic [19:0] sum_sat;
  logic [17:0] score;
  logic [4:0]  cnt_inc;
  logic        closes;
  logic [2:0]  quiet_inc;
  logic        is_active, is_quiet, is_fall;

  // absolute differences against the previous sample
  always_comb begin
    dx = 17'(accel_x) - 17'(prev_x);
    dy = 17'(accel_y) - 17'(prev_y);
    dz = 17'(accel_z) - 17'(prev_z);
    ax = dx[16] ? 17'(-dx) : 17'(dx);
    ay = dy[16] ? 17'(-dy) : 17'(dy);
    az = dz[16] ? 17'(-dz) : 17'(dz);
    sabs = 18'(ax) + 18'(ay) + 18'(az);
  end

  // window accumulate with saturation, score on close
  always_comb begin
    sum_wide = {1'b0, window_sum} + 21'(sabs);
    sum_sat = sum_wide[20] ? SUM_MAX : sum_wide[19:0];
    score = 18'(sum_sat / WIN_DIV);
    cnt_inc = {1'b0, samples_in_window} + 5'd1;
    closes = (cnt_inc >= WIN_LEN);
    is_active = (score > cfg.active_threshold);
    is_quiet = (score <= cfg.quiet_threshold);
    is_fall = (score >= cfg.fall_threshold);
    quiet_inc = {1'b0, quiet_run} + 3'd1;
  end

  // window, classifier and fall detector next state
  always_comb begin
    window_sum_next = sum_sat;
    samples_in_window_next = cnt_inc[3:0];
    level_state_next = level_state;
    quiet_run_next = quiet_run;
    fall_run_next = fall_run;
    fall_flag_next = fall_flag;
    last_score_next = last_score;
    if (closes) begin
      window_sum_next = '0;
      samples_in_window_next = '0;
      last_score_next = score;
      case (level_state)
        LVL_STILL: begin
          if (is_active) begin
            level_state_next = LVL_MOVING;
          end else if (!is_quiet) begin
            level_state_next = LVL_MICRO;
          end
        end
        LVL_MICRO: begin
          if (is_active) begin
            level_state_next = LVL_MOVING;
          end else if (is_quiet) begin
            if (quiet_inc >= 3'd2) begin
              level_state_next = LVL_STILL;
              quiet_run_next = '0;
            end else begin
              quiet_run_next = quiet_inc[1:0];
            end
          end else begin
            quiet_run_next = '0;
          end
        end
        LVL_MOVING: begin
          if (is_quiet) begin
            if (quiet_inc >= 3'd2) begin
              level_state_next = LVL_MICRO;
              quiet_run_next = '0;
            end else begin
              quiet_run_next = quiet_inc[1:0];
            end
          end else begin
            quiet_run_next = '0;
          end
        end
        default: begin
        end
      endcase
      if (is_fall) begin
        if (fall_run == {1'b0, cfg.fall_windows}) begin
          fall_flag_next = 1'b1;
        end
        if (fall_run < FALL_RUN_MAX) begin
          fall_run_next = fall_run + 5'd1;
        end
      end else begin
        fall_run_next = '0;
      end
    end
  end

  // state registers, updated per accepted transaction
  always_ff @(posedge clk) begin
    if (rst) begin
      prev_x <= '0;
      prev_y <= '0;
      prev_z <= '0;
      window_sum <= '0;
      samples_in_window <= '0;
      level_state <= LVL_STILL;
      quiet_run <= '0;
      fall_run <= '0;
      fall_flag <= 1'b0;
      last_score <= '0;
    end else if (fire) begin
      prev_x <= accel_x;
      prev_y <= accel_y;
      prev_z <= accel_z;
      window_sum <= window_sum_next;
      samples_in_window <= samples_in_window_next;
      level_state <= level_state_next;
      quiet_run <= quiet_run_next;
      fall_run <= fall_run_next;
      fall_flag <= fall_flag_next;
      last_score <= last_score_next;
    end
  end

  // result as seen after this transaction
  always_comb begin
    res.window_done = closes;
    res.window_score = last_score_next;
    res.motion_level = level_state_next;
    res.fall_seen = fall_flag_next;
  end

  `AFC_ASSERT_NEXT(a_fall_sticky, fall_flag, fall_flag)
  `AFC_ASSERT_NEXT(a_window_restart, fire && closes, samples_in_window == 4'd0)
  `AFC_ASSERT_NOW(a_level_legal, 1'b1, level_state <= LVL_MOVING)

endmodule

`default_nettype wire

>>> dv/accel_activity_fall_classifier_tb.sv
`timescale 1ns / 1ps

module accel_activity_fall_classifier_tb;
  import afc_pkg::*;

  localparam int IDLE_LIMIT = 2000;
  localparam int MAX_SAMPLE_SUM = 196605;

  typedef struct {
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic signed [15:0] z;
  } sample_t;

  typedef enum {
    SEG_NOISE,
    SEG_QUIET,
    SEG_MICRO,
    SEG_ACTIVE,
    SEG_FALL,
    SEG_EDGE
  } segment_kind_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic signed [15:0] accel_x = '0;
  logic signed [15:0] accel_y = '0;
  logic signed [15:0] accel_z = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic window_done;
  logic [17:0] window_score;
  logic [1:0] motion_level;
  logic fall_seen;
  logic cfg_we = 1'b0;
  logic [1:0] cfg_index = '0;
  logic [17:0] cfg_data = '0;

  accel_activity_fall_classifier uut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .accel_x(accel_x),
    .accel_y(accel_y),
    .accel_z(accel_z),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .window_done(window_done),
    .window_score(window_score),
    .motion_level(motion_level),
    .fall_seen(fall_seen),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  // shadow copy of the thresholds
  logic [17:0] th_quiet = QUIET_TH_RST;
  logic [17:0] th_active = ACTIVE_TH_RST;
  logic [17:0] th_fall = FALL_TH_RST;
  logic [3:0] fall_need = FALL_WIN_RST;

  // shadow copy of the classifier state
  logic signed [15:0] last_x = '0;
  logic signed [15:0] last_y = '0;
  logic signed [15:0] last_z = '0;
  logic [19:0] acc_sum = '0;
  logic [3:0] acc_count = '0;
  logic [1:0] level = LVL_STILL;
  logic [1:0] quiet_count = '0;
  logic [4:0] high_count = '0;
  logic fall_latched = 1'b0;
  logic [17:0] held_score = '0;

  sample_t pending_samples[$];
  result_t expected_results[$];
  int mismatch_count = 0;
  int results_seen = 0;

  // generator's view of the last queued sample
  int gen_x = 0;
  int gen_y = 0;
  int gen_z = 0;

  // advance the shadow state by one sample and return what the block should report
  function automatic result_t classify_sample(input logic signed [15:0] x,
                                              input logic signed [15:0] y,
                                              input logic signed [15:0] z);
    int dx;
    int dy;
    int dz;
    int sum;
    result_t r;
    dx = int'(x) - int'(last_x);
    dy = int'(y) - int'(last_y);
    dz = int'(z) - int'(last_z);
    if (dx < 0) dx = -dx;
    if (dy < 0) dy = -dy;
    if (dz < 0) dz = -dz;
    last_x = x;
    last_y = y;
    last_z = z;
    sum = int'(acc_sum) + dx + dy + dz;
    if (sum > int'(SUM_MAX)) sum = int'(SUM_MAX);
    r.window_done = 1'b0;
    if (int'(acc_count) + 1 >= WINDOW_SAMPLES) begin
      held_score = 18'(sum / WINDOW_SAMPLES);
      r.window_done = 1'b1;
      // motion level update
      case (level)
        LVL_STILL: begin
          if (held_score > th_active) begin
            level = LVL_MOVING;
          end else if (held_score > th_quiet) begin
            level = LVL_MICRO;
          end
        end
        LVL_MICRO: begin
          if (held_score > th_active) begin
            level = LVL_MOVING;
          end else if (held_score <= th_quiet) begin
            quiet_count = quiet_count + 2'd1;
            if (quiet_count >= 2'd2) begin
              level = LVL_STILL;
              quiet_count = '0;
            end
          end else begin
            quiet_count = '0;
          end
        end
        LVL_MOVING: begin
          if (held_score <= th_quiet) begin
            quiet_count = quiet_count + 2'd1;
            if (quiet_count >= 2'd2) begin
              level = LVL_MICRO;
              quiet_count = '0;
            end
          end else begin
            quiet_count = '0;
          end
        end
        default: begin
        end
      endcase
      // fall detector
      if (held_score >= th_fall) begin
        if (high_count == {1'b0, fall_need}) fall_latched = 1'b1;
        if (high_count < FALL_RUN_MAX) high_count = high_count + 5'd1;
      end else begin
        high_count = '0;
      end
      acc_sum = '0;
      acc_count = '0;
    end else begin
      acc_sum = 20'(sum);
      acc_count = acc_count + 4'd1;
    end
    r.window_score = held_score;
    r.motion_level = level;
    r.fall_seen = fall_latched;
    return r;
  endfunction

  task automatic report_mismatch(input string what, input int unsigned got,
                                 input int unsigned want);
    mismatch_count++;
    if (mismatch_count <= 30)
      $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $time);
  endtask

  // sender: bursts of random length separated by random gaps
  int burst_left = 0;
  int gap_left = 0;

  always @(posedge clk) begin : sender
    sample_t next_item;
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        expected_results.push_back(classify_sample(accel_x, accel_y, accel_z));
      end
      if (in_valid && in_stall) begin
        // hold the stalled transaction
      end else if (gap_left > 0) begin
        gap_left--;
        in_valid <= 1'b0;
      end else if (pending_samples.size() > 0) begin
        next_item = pending_samples.pop_front();
        in_valid <= 1'b1;
        accel_x <= next_item.x;
        accel_y <= next_item.y;
        accel_z <= next_item.z;
        if (burst_left <= 1) begin
          burst_left = $urandom_range(1, 40);
          if ($urandom_range(0, 2) == 0) gap_left = 0;
          else if ($urandom_range(0, 9) == 0) gap_left = $urandom_range(9, 20);
          else gap_left = $urandom_range(1, 8);
        end else begin
          burst_left--;
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver: checks each result and stalls on its own pattern
  int hold_left = 0;
  int stall_mode = 0;
  int mode_left = 0;
  bit long_hold_done = 1'b0;

  always @(posedge clk) begin : receiver
    result_t want;
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        results_seen++;
        if (expected_results.size() == 0) begin
          report_mismatch("unexpected transaction, score", window_score, 0);
        end else begin
          want = expected_results.pop_front();
          if (window_done !== want.window_done)
            report_mismatch("window_done", window_done, want.window_done);
          if (window_score !== want.window_score)
            report_mismatch("window_score", window_score, want.window_score);
          if (motion_level !== want.motion_level)
            report_mismatch("motion_level", motion_level, want.motion_level);
          if (fall_seen !== want.fall_seen)
            report_mismatch("fall_seen", fall_seen, want.fall_seen);
        end
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (!long_hold_done && results_seen >= 150) begin
        // one long hold-off so the input side backs up
        long_hold_done = 1'b1;
        hold_left = 80;
        out_stall <= 1'b1;
      end else if ($urandom_range(0, 399) == 0) begin
        hold_left = $urandom_range(20, 50);
        out_stall <= 1'b1;
      end else begin
        if (mode_left == 0) begin
          stall_mode = $urandom_range(0, 3);
          mode_left = $urandom_range(10, 120);
        end else begin
          mode_left--;
        end
        case (stall_mode)
          0: out_stall <= 1'b0;
          1: out_stall <= ($urandom_range(0, 3) == 0);
          2: out_stall <= ($urandom_range(0, 3) != 0);
          default: out_stall <= ($urandom_range(0, 1) == 0);
        endcase
      end
    end
  end

  // watchdog on cycles without any transaction
  int quiet_cycles = 0;

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= IDLE_LIMIT) begin
      $display("FAIL accel_activity_fall_classifier");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic push_sample(input logic signed [15:0] x, input logic signed [15:0] y,
                             input logic signed [15:0] z);
    sample_t s;
    s.x = x;
    s.y = y;
    s.z = z;
    pending_samples.push_back(s);
    gen_x = x;
    gen_y = y;
    gen_z = z;
  endtask

  // move one axis by delta in a random direction, staying in range
  function automatic logic signed [15:0] step_axis(input int from, input int delta);
    int up;
    int dn;
    up = from + delta;
    dn = from - delta;
    if ($urandom_range(0, 1) == 1) begin
      if (up <= 32767) return 16'(up);
      if (dn >= -32768) return 16'(dn);
    end else begin
      if (dn >= -32768) return 16'(dn);
      if (up <= 32767) return 16'(up);
    end
    return (from < 0) ? 16'sh7FFF : 16'sh8000;
  endfunction

  // queue a sample whose summed axis change is close to target
  task automatic push_step(input int target);
    int part;
    if (target < 0) target = 0;
    if (target > MAX_SAMPLE_SUM) target = MAX_SAMPLE_SUM;
    part = target / 3;
    push_sample(step_axis(gen_x, part), step_axis(gen_y, part),
                step_axis(gen_z, target - 2 * part));
  endtask

  // random segments: mostly scores aimed at the current thresholds, some noise
  task automatic fill_random(input int count);
    int added;
    int len;
    int target;
    int pick;
    segment_kind_t kind;
    added = 0;
    while (added < count) begin
      pick = $urandom_range(0, 99);
      if (pick < 12) kind = SEG_NOISE;
      else if (pick < 32) kind = SEG_QUIET;
      else if (pick < 52) kind = SEG_MICRO;
      else if (pick < 67) kind = SEG_ACTIVE;
      else if (pick < 82) kind = SEG_FALL;
      else kind = SEG_EDGE;
      len = (kind == SEG_FALL) ? $urandom_range(6, 24) : $urandom_range(1, 12);
      case (kind)
        SEG_QUIET: target = $urandom_range(0, th_quiet);
        SEG_MICRO: target = $urandom_range(th_quiet, th_active);
        SEG_ACTIVE: target = th_active + $urandom_range(0, 20000);
        SEG_FALL: target = th_fall + $urandom_range(0, 40000);
        SEG_EDGE: begin
          pick = $urandom_range(0, 2);
          target = (pick == 0) ? th_quiet : (pick == 1) ? th_active : th_fall;
          target = target + $urandom_range(0, 4) - 2;
        end
        default: target = 0;
      endcase
      for (int i = 0; i < len && added < count; i++) begin
        if (kind == SEG_NOISE) push_sample(16'($urandom), 16'($urandom), 16'($urandom));
        else push_step(target);
        added++;
      end
    end
  endtask

  task automatic wait_drained();
    while (pending_samples.size() != 0 || in_valid || expected_results.size() != 0)
      @(posedge clk);
  endtask

  // write all four registers in back-to-back cycles while idle
  task automatic program_thresholds(input logic [17:0] quiet, input logic [17:0] active,
                                    input logic [17:0] fall, input logic [17:0] windows);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= REG_QUIET_TH;
    cfg_data <= quiet;
    @(posedge clk);
    cfg_index <= REG_ACTIVE_TH;
    cfg_data <= active;
    @(posedge clk);
    cfg_index <= REG_FALL_TH;
    cfg_data <= fall;
    @(posedge clk);
    cfg_index <= REG_FALL_WIN;
    cfg_data <= windows;
    @(posedge clk);
    cfg_we <= 1'b0;
    th_quiet = quiet;
    th_active = active;
    th_fall = fall;
    fall_need = windows[3:0];
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // full-scale swings: moving and the fall flag on the fourth high window
    push_sample(16'sh0000, 16'sh0000, 16'sh0000);
    for (int i = 0; i < 9; i++) begin
      if (i % 2 == 0) push_sample(16'sh7FFF, 16'sh7FFF, 16'sh7FFF);
      else push_sample(16'sh8000, 16'sh8000, 16'sh8000);
    end
    // quiet windows step the level down
    for (int i = 0; i < 8; i++) push_sample(16'sh0000, 16'sh0000, 16'sh0000);
    // scores right at the quiet and active boundaries
    push_step(1001);
    push_step(1001);
    push_step(8000);
    push_step(8000);
    push_step(8001);
    push_step(8001);
    fill_random(250);
    wait_drained();

    // lowest settings: every window counts as a fall, run counter saturates
    program_thresholds(18'd0, 18'd0, 18'd0, 18'h3FFF0);
    fill_random(150);
    wait_drained();

    // highest settings
    program_thresholds(18'h3FFFF, 18'h3FFFF, 18'h3FFFF, 18'h3FFFF);
    fill_random(150);
    wait_drained();

    // thresholds out of their usual order
    program_thresholds(18'd20000, 18'd500, 18'd100, 18'h2A5C7);
    fill_random(200);
    wait_drained();

    for (int p = 0; p < 3; p++) begin
      program_thresholds(18'($urandom_range(0, 4000)), 18'($urandom_range(0, 30000)),
                         18'($urandom_range(0, 90000)), 18'($urandom_range(0, 262143)));
      fill_random(150);
      wait_drained();
    end

    repeat (4) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("PASS accel_activity_fall_classifier");
    end else begin
      $display("FAIL accel_activity_fall_classifier");
    end
    $finish;
  end

endmodule
